[sv/svrd_pkg.sv]
package svrd_pkg;

  // Default build parameters.
  localparam int unsigned SAMPLE_RATE_DEF = 48000;
  localparam int unsigned SINE_DEPTH_DEF  = 1024;

  // Note table.
  localparam int unsigned NOTES        = 128;
  localparam int unsigned NOTE_CLASSES = 12;

  // Lowest octave of the equal-tempered scale, in nanohertz.
  localparam logic [63:0] OCT_NHZ [NOTE_CLASSES] = '{
    64'd8175798916,  64'd8661957218,  64'd9177023997,  64'd9722718241,
    64'd10300861154, 64'd10913382232, 64'd11562325710, 64'd12249857374,
    64'd12978271799, 64'd13750000000, 64'd14567617547, 64'd15433853164
  };

  // Sine polynomial in Q30, innermost coefficient first.
  localparam logic [31:0] POLY_C0 = 32'd172272;
  localparam logic [31:0] POLY_COEF [4] = '{
    32'd5026996, 32'd85569304, 32'd693598669, 32'd1686629713
  };

  // Gain and release constants.
  localparam logic [16:0] REL_ONE   = 17'd65536;
  localparam logic [16:0] REL_FLOOR = 17'd327;
  localparam logic [14:0] SMP_MAX   = 15'h7fff;

  // Shared serial arithmetic unit.
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned MUL_DIGIT = 4;
  localparam int unsigned MUL_STEPS = MUL_W / MUL_DIGIT;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned DVD_W     = 48;
  localparam int unsigned DSOR_W    = 17;
  localparam int unsigned QUO_W     = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W + 1);

  localparam logic [DSOR_W-1:0] DIV_GAIN = 17'd20;
  localparam logic [DSOR_W-1:0] DIV_REL  = 17'd100;

  typedef enum logic [1:0] {
    CMD_ON   = 2'd0,
    CMD_OFF  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAINDIV,
    ST_KMUL,
    ST_UDIV,
    ST_Z2MUL,
    ST_POLY,
    ST_MAGMUL,
    ST_G1MUL,
    ST_G2MUL,
    ST_RELDIV,
    ST_ADV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mul_go;
    logic div_go;
  } alu_ctl_t;

endpackage

[sv/svrd_in_if.sv]
interface svrd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [6:0]  note;
  logic [15:0] velocity;
  logic        allow_tail;

  modport source (output valid, cmd, note, velocity, allow_tail, input ready);
  modport sink   (input valid, cmd, note, velocity, allow_tail, output ready);
endinterface

[sv/svrd_out_if.sv]
interface svrd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               voice_active;

  modport source (output valid, sample, voice_active, input ready);
  modport sink   (input valid, sample, voice_active, output ready);
endinterface

[sv/sine_voice_with_release_decay.sv]
// The arithmetic of note on and sample tick runs on the shared serial unit,
// a 4-bit-per-cycle multiplier and a 48-step restoring divider. A new
// command is taken only once the sequencer is back idle from the last one.
// A tick on a silent voice skips the unit.
// Synchronous active-high reset silences the voice: phase, step, level and
// release gain clear to zero and no result is pending.
module sine_voice_with_release_decay #(
  parameter int unsigned SAMPLE_RATE      = svrd_pkg::SAMPLE_RATE_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = svrd_pkg::SINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  svrd_in_if.sink     req,
  svrd_out_if.source  rsp
);
  import svrd_pkg::*;

  // Sample rate in nanohertz units, the divisor of the increment table.
  localparam logic [63:0] ND = 64'(SAMPLE_RATE) * 64'd1000000000;
  localparam logic [DSOR_W-1:0] DEPTH = DSOR_W'(SINE_TABLE_DEPTH);

  // The phase increment of each MIDI note, rounded to nearest and wrapped
  // to 32 bits. Built entirely at elaboration.
  function automatic logic [NOTES-1:0][31:0] build_step_rom();
    logic [NOTES-1:0][31:0] rom;
    logic [63:0] q;
    logic [63:0] a;
    logic [63:0] hi;
    logic [63:0] rm;
    logic [63:0] lo;
    for (int n = 0; n < NOTES; n++) begin
      q  = OCT_NHZ[n % NOTE_CLASSES] << (n / NOTE_CLASSES);
      a  = q << 16;
      hi = a / ND;
      rm = a % ND;
      lo = ((rm << 16) + ND / 2) / ND;
      rom[n] = 32'((hi << 16) + lo);
    end
    return rom;
  endfunction

  localparam logic [NOTES-1:0][31:0] STEP_ROM = build_step_rom();

  // Architectural voice state.
  logic [31:0] phase;
  logic [31:0] phase_step;
  logic [15:0] gain_level;
  logic [16:0] rg;

  // Per-sample working registers.
  state_t      state, state_next;
  logic [30:0] z;
  logic [30:0] z2;
  logic [1:0]  pidx;
  logic        neg;
  logic [14:0] res;

  // Output register; it lets the next command in while a sample waits.
  logic               out_valid;
  logic signed [15:0] out_sample;
  logic               out_active;
  logic               out_load;

  // Serial arithmetic unit and its operands.
  alu_ctl_t            alu_ctl;
  logic [MUL_W-1:0]    op_a;
  logic [MUL_W-1:0]    op_b;
  logic [DVD_W-1:0]    dvd;
  logic [DSOR_W-1:0]   dsor;
  logic                alu_busy;
  logic [PROD_W-1:0]   alu_prod;
  logic [QUO_W-1:0]    alu_quo;

  svrd_serial_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (alu_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .dvd  (dvd),
    .dsor (dsor),
    .busy (alu_busy),
    .prod (alu_prod),
    .quo  (alu_quo)
  );

  logic        acc;
  logic [30:0] z_raw;
  logic [30:0] z_calc;
  logic [31:0] acc_new;
  logic [31:0] mag_sum;
  logic [16:0] mag_raw;
  logic [14:0] mag;
  logic [15:0] res_g1;
  logic [16:0] res_g2;
  logic [23:0] rel_dvd;
  logic [17:0] gain_dvd;
  cmd_t        cmd;

  assign acc = req.valid && req.ready;
  assign cmd = cmd_t'(req.cmd);

  // The sine argument is the table index scaled back to a phase. Odd
  // quadrants fold the angle, so that the polynomial sees 0..pi/2 only.
  assign z_raw  = {1'b0, alu_quo[29:0]};
  assign z_calc = alu_quo[30] ? (31'h4000_0000 - z_raw) : z_raw;

  // Horner step: acc = c - (z2 * acc) >> 30.
  assign acc_new = POLY_COEF[pidx] - alu_prod[61:30];

  // Final sine magnitude, rounded to Q15 and limited to full scale.
  assign mag_sum = {1'b0, alu_prod[60:30]} + 32'd16384;
  assign mag_raw = mag_sum[31:15];
  assign mag     = (mag_raw > 17'(SMP_MAX)) ? SMP_MAX : mag_raw[14:0];

  // Sample magnitude, rounded half up, for the sustained and the releasing
  // voice. The rounding adds only the bit just below the cut.
  assign res_g1 = {1'b0, alu_prod[30:16]} + {15'b0, alu_prod[15]};
  assign res_g2 = {1'b0, alu_prod[47:32]} + {16'b0, alu_prod[31]};

  // Dividends for the rounded constant divisions.
  assign rel_dvd  = 24'(rg) * 24'd99 + 24'd50;
  assign gain_dvd = 18'(req.velocity) * 18'd3 + 18'd10;

  // Next state, handshake and unit commands.
  always_comb begin
    state_next     = state;
    req.ready      = 1'b0;
    alu_ctl.mul_go = 1'b0;
    alu_ctl.div_go = 1'b0;
    op_a           = '0;
    op_b           = '0;
    dvd            = '0;
    dsor           = '0;
    out_load       = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          case (cmd)
            CMD_ON: begin
              dvd            = DVD_W'(gain_dvd);
              dsor           = DIV_GAIN;
              alu_ctl.div_go = 1'b1;
              state_next     = ST_GAINDIV;
            end
            CMD_TICK: begin
              if (phase_step == '0) begin
                state_next = ST_OUT;
              end else begin
                op_a           = MUL_W'(DEPTH);
                op_b           = phase;
                alu_ctl.mul_go = 1'b1;
                state_next     = ST_KMUL;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_GAINDIV: begin
        if (!alu_busy) state_next = ST_IDLE;
      end
      ST_KMUL: begin
        if (!alu_busy) begin
          dvd            = {alu_prod[47:32], 32'b0};
          dsor           = DEPTH;
          alu_ctl.div_go = 1'b1;
          state_next     = ST_UDIV;
        end
      end
      ST_UDIV: begin
        if (!alu_busy) begin
          op_a           = MUL_W'(z_calc);
          op_b           = MUL_W'(z_calc);
          alu_ctl.mul_go = 1'b1;
          state_next     = ST_Z2MUL;
        end
      end
      ST_Z2MUL: begin
        if (!alu_busy) begin
          op_a           = MUL_W'(alu_prod[60:30]);
          op_b           = POLY_C0;
          alu_ctl.mul_go = 1'b1;
          state_next     = ST_POLY;
        end
      end
      ST_POLY: begin
        if (!alu_busy) begin
          op_a           = (pidx == 2'd3) ? MUL_W'(z) : MUL_W'(z2);
          op_b           = acc_new;
          alu_ctl.mul_go = 1'b1;
          if (pidx == 2'd3) state_next = ST_MAGMUL;
        end
      end
      ST_MAGMUL: begin
        if (!alu_busy) begin
          op_a           = MUL_W'(mag);
          op_b           = MUL_W'(gain_level);
          alu_ctl.mul_go = 1'b1;
          state_next     = ST_G1MUL;
        end
      end
      ST_G1MUL: begin
        if (!alu_busy) begin
          if (rg != '0) begin
            op_a           = MUL_W'(alu_prod[30:0]);
            op_b           = MUL_W'(rg);
            alu_ctl.mul_go = 1'b1;
            state_next     = ST_G2MUL;
          end else begin
            state_next = ST_ADV;
          end
        end
      end
      ST_G2MUL: begin
        if (!alu_busy) begin
          dvd            = DVD_W'(rel_dvd);
          dsor           = DIV_REL;
          alu_ctl.div_go = 1'b1;
          state_next     = ST_RELDIV;
        end
      end
      ST_RELDIV: begin
        if (!alu_busy) state_next = ST_ADV;
      end
      ST_ADV: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Voice state. A note on restarts the phase and cancels any release; a
  // note off drops the step to zero or arms the release at unity if none runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      phase_step <= '0;
      gain_level <= '0;
      rg         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc && cmd == CMD_ON) begin
            phase      <= '0;
            rg         <= '0;
            phase_step <= STEP_ROM[req.note];
          end else if (acc && cmd == CMD_OFF) begin
            if (req.allow_tail) begin
              if (rg == '0) rg <= REL_ONE;
            end else begin
              phase_step <= '0;
            end
          end
        end
        ST_GAINDIV: begin
          if (!alu_busy) gain_level <= alu_quo[15:0];
        end
        ST_RELDIV: begin
          // The release gain decays by 0.99 per sample and the voice ends
          // once it has fallen to 0.005 or below.
          if (!alu_busy) begin
            rg <= alu_quo[16:0];
            if (alu_quo[16:0] <= REL_FLOOR) phase_step <= '0;
          end
        end
        ST_ADV: begin
          phase <= phase + phase_step;
        end
        default: ;
      endcase
    end
  end

  // Working registers of one sample.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        neg  <= 1'b0;
        res  <= '0;
        pidx <= '0;
      end
      ST_UDIV: begin
        if (!alu_busy) begin
          z   <= z_calc;
          neg <= alu_quo[31];
        end
      end
      ST_Z2MUL: begin
        if (!alu_busy) z2 <= alu_prod[60:30];
      end
      ST_POLY: begin
        if (!alu_busy) pidx <= pidx + 2'd1;
      end
      ST_G1MUL: begin
        if (!alu_busy) begin
          res <= (res_g1 > 16'(SMP_MAX)) ? SMP_MAX : res_g1[14:0];
        end
      end
      ST_G2MUL: begin
        if (!alu_busy) begin
          res <= (res_g2 > 17'(SMP_MAX)) ? SMP_MAX : res_g2[14:0];
        end
      end
      default: ;
    endcase
  end

  // Output register. The sign comes from the half of the sine cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= neg ? -$signed({1'b0, res}) : $signed({1'b0, res});
      out_active <= (phase_step != '0);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.sample       = out_sample;
  assign rsp.voice_active = out_active;

  // The serial unit is never left running once the sequencer is back idle.
  a_idle_alu_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !alu_busy)
    else $error("serial unit busy while sequencer idle");

  // A tick on a silent voice goes straight to the output stage.
  a_silent_tick: assert property (@(posedge clk) disable iff (rst)
    (acc && cmd == CMD_TICK && phase_step == '0) |=> state == ST_OUT)
    else $error("silent tick did not go straight to output");

  // The release gain never rises above unity.
  a_rel_bound: assert property (@(posedge clk) disable iff (rst)
    rg <= REL_ONE)
    else $error("release gain above unity");

  // The release multiply is only reached for a releasing voice.
  a_rel_path: assert property (@(posedge clk) disable iff (rst)
    (state == ST_G2MUL || state == ST_RELDIV) |-> rg != '0)
    else $error("release path taken without release gain");

endmodule

[sv/svrd_serial_alu.sv]
module svrd_serial_alu (
  input  logic                                clk,
  input  logic                                rst,
  input  svrd_pkg::alu_ctl_t                  ctl,
  input  logic [svrd_pkg::MUL_W-1:0]          op_a,
  input  logic [svrd_pkg::MUL_W-1:0]          op_b,
  input  logic [svrd_pkg::DVD_W-1:0]          dvd,
  input  logic [svrd_pkg::DSOR_W-1:0]         dsor,
  output logic                                busy,
  output logic [svrd_pkg::PROD_W-1:0]         prod,
  output logic [svrd_pkg::QUO_W-1:0]          quo
);
  import svrd_pkg::*;

  localparam int unsigned SUM_W = MUL_W + MUL_DIGIT;

  logic [MUL_W-1:0]     mcand;
  logic [MUL_CNT_W-1:0] mcnt;
  logic [SUM_W-1:0]     msum;

  logic [DVD_W-1:0]     dvd_sr;
  logic [DSOR_W-1:0]    dsor_q;
  logic [DSOR_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] dcnt;
  logic [DSOR_W:0]      trial;
  logic                 qbit;

  // One multiplier digit per cycle: add the partial product to the upper
  // half and shift the whole product right by one digit.
  assign msum = {{MUL_DIGIT{1'b0}}, prod[PROD_W-1:MUL_W]}
              + SUM_W'(mcand) * SUM_W'(prod[MUL_DIGIT-1:0]);

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, dvd_sr[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dsor_q});

  assign busy = (mcnt != '0) || (dcnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= '0;
      dcnt <= '0;
    end else begin
      if (ctl.mul_go) begin
        mcnt <= MUL_CNT_W'(MUL_STEPS);
      end else if (mcnt != '0) begin
        mcnt <= mcnt - 1'b1;
      end
      if (ctl.div_go) begin
        dcnt <= DIV_CNT_W'(DVD_W);
      end else if (dcnt != '0) begin
        dcnt <= dcnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_go) begin
      mcand <= op_a;
      prod  <= {{MUL_W{1'b0}}, op_b};
    end else if (mcnt != '0) begin
      prod <= {msum, prod[MUL_W-1:MUL_DIGIT]};
    end
    if (ctl.div_go) begin
      dvd_sr <= dvd;
      dsor_q <= dsor;
      rem    <= '0;
      quo    <= '0;
    end else if (dcnt != '0) begin
      dvd_sr <= {dvd_sr[DVD_W-2:0], 1'b0};
      rem    <= qbit ? DSOR_W'(trial - {1'b0, dsor_q}) : trial[DSOR_W-1:0];
      quo    <= {quo[QUO_W-2:0], qbit};
    end
  end

endmodule
